// ===== rtl/lfse_pkg.sv =====
// ----------------------------------------------------------------------------
// lfse_pkg: shared definitions for the LED frame smooth encoder
// Store geometry, register map, line-code table and the structs passed
// between the encoder's units.
// ----------------------------------------------------------------------------
`default_nettype none

package lfse_pkg;

    localparam int LED_COUNT = 256;
    localparam int LED_AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CHAN_NUM  = 4;

    // channel lanes, in the byte order of the stored colour word
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_WHITE = 3;

    // configuration port
    localparam int          APB_AW          = 3;
    localparam logic        REG_SMOOTH_STEP = 1'b0;   // word index of smooth_step
    localparam logic [7:0]  STEP_RESET      = 8'd96;
    localparam logic [7:0]  STEP_FULL       = 8'd255;
    localparam logic [16:0] ROUND_BIAS      = 17'd127;

    // two data bits, MSB first, to one line-code byte
    localparam logic [7:0] PAIR_CODE [4] = '{8'h88, 8'h8C, 8'hC8, 8'hCC};

    typedef struct packed {
        logic              en;
        logic [LED_AW-1:0] addr;
        logic [31:0]       data;
    } t_mem_wr;

    typedef struct packed {
        logic load;
        logic frame_end;
    } t_s1_ctl;

    function automatic logic [31:0] f_line_code(input logic [7:0] value);
        logic [31:0] word;
        word = '0;
        for (int i = 0; i < 4; i++) begin
            word[31 - 8*i -: 8] = PAIR_CODE[value[7 - 2*i -: 2]];
        end
        return word;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lfse_mem.sv =====
// ----------------------------------------------------------------------------
// lfse_mem: shown-colour store
// One write and one registered read per cycle; an entry never written
// since reset reads as zero through its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module lfse_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_rd_en,
    input  wire logic [lfse_pkg::LED_AW-1:0] i_rd_addr,
    input  wire lfse_pkg::t_mem_wr         i_wr,
    output logic [31:0]                    o_rd_data
);

    logic [31:0]                    r_mem [lfse_pkg::LED_COUNT];
    logic [lfse_pkg::LED_COUNT-1:0] r_valid;
    logic [31:0]                    r_rd_data;
    logic                           r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : 32'd0;

endmodule

`default_nettype wire

// ===== rtl/lfse_lane.sv =====
// ----------------------------------------------------------------------------
// lfse_lane: one colour channel
// Blends the shown value toward the target with rounding and encodes the
// result in SPI line code.
// ----------------------------------------------------------------------------
`default_nettype none

module lfse_lane (
    input  wire logic [7:0] i_cur,
    input  wire logic [7:0] i_tgt,
    input  wire logic [7:0] i_k,
    output logic [7:0]      o_nxt,
    output logic [31:0]     o_code
);

    logic [15:0] w_prod_cur;
    logic [15:0] w_prod_tgt;
    logic [16:0] w_acc;
    logic [16:0] w_quot;

    assign w_prod_cur = i_cur * (lfse_pkg::STEP_FULL - i_k);
    assign w_prod_tgt = i_tgt * i_k;
    assign w_acc      = {1'b0, w_prod_cur} + {1'b0, w_prod_tgt} + lfse_pkg::ROUND_BIAS;

    // divide by 255: exact for numerators up to 255*255+127
    assign w_quot = w_acc + {8'd0, w_acc[16:8]} + 17'd1;
    assign o_nxt  = w_quot[15:8];
    assign o_code = lfse_pkg::f_line_code(o_nxt);

endmodule

`default_nettype wire

// ===== rtl/lfse_merge.sv =====
// ----------------------------------------------------------------------------
// lfse_merge: result merge and output register
// Combines the lane results into the change and frame-dirty flags and
// holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lfse_merge (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire lfse_pkg::t_s1_ctl                      i_ctl,
    input  wire logic [31:0]                            i_old_word,
    input  wire logic [31:0]                            i_new_word,
    input  wire logic [lfse_pkg::CHAN_NUM-1:0][31:0]    i_code,
    input  wire logic                                   i_stall,
    output logic                                        o_free,
    output logic                                        o_valid,
    output logic [31:0]                                 o_code_green,
    output logic [31:0]                                 o_code_red,
    output logic [31:0]                                 o_code_blue,
    output logic [31:0]                                 o_code_white,
    output logic                                        o_led_changed,
    output logic                                        o_frame_dirty,
    output logic                                        o_frame_done
);

    logic        r_valid;
    logic        r_dirty;
    logic        n_dirty;
    logic        w_changed;
    logic        w_dirty_now;
    logic [31:0] r_code_green;
    logic [31:0] r_code_red;
    logic [31:0] r_code_blue;
    logic [31:0] r_code_white;
    logic        r_changed;
    logic        r_frame_dirty;
    logic        r_frame_done;

    assign w_changed   = i_new_word != i_old_word;
    assign w_dirty_now = r_dirty | w_changed;
    assign n_dirty     = i_ctl.frame_end ? 1'b0 : w_dirty_now;
    assign o_free      = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_valid <= 1'b1;
                r_dirty <= n_dirty;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_code_green  <= i_code[lfse_pkg::CH_GREEN];
            r_code_red    <= i_code[lfse_pkg::CH_RED];
            r_code_blue   <= i_code[lfse_pkg::CH_BLUE];
            r_code_white  <= i_code[lfse_pkg::CH_WHITE];
            r_changed     <= w_changed;
            r_frame_dirty <= w_dirty_now;
            r_frame_done  <= i_ctl.frame_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_code_green  = r_code_green;
    assign o_code_red    = r_code_red;
    assign o_code_blue   = r_code_blue;
    assign o_code_white  = r_code_white;
    assign o_led_changed = r_changed;
    assign o_frame_dirty = r_frame_dirty;
    assign o_frame_done  = r_frame_done;

endmodule

`default_nettype wire

// ===== rtl/led_frame_smooth_encode_unit.sv =====
// ----------------------------------------------------------------------------
// led_frame_smooth_encode_unit: LED colour smoothing and SPI line encoder
// Blends each LED's shown RGBW colour toward its target and emits the new
// colour as SPI line code, with per-LED change and frame-dirty flags.
// ----------------------------------------------------------------------------
// One LED is taken per clock cycle, sustained, while the output channel does
// not stall; each LED passes the lane stage register and then the output
// register. The rate is set by the shown-colour store: each LED costs one
// read and one write of that single-port-per-direction memory, and an LED
// that follows an update of the same entry (a one-LED frame) gets the fresh
// colour through a bypass, so no bubble is needed. Four channel lanes blend
// in parallel in the cycle after the read. The store reads as all zero after
// reset with no clearing pass. Write smooth_step only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module led_frame_smooth_encode_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [7:0]                    i_target_red,
    input  wire logic [7:0]                    i_target_green,
    input  wire logic [7:0]                    i_target_blue,
    input  wire logic [7:0]                    i_target_white,
    input  wire logic                          i_jump_now,
    input  wire logic                          i_frame_end,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [31:0]                        o_code_green,
    output logic [31:0]                        o_code_red,
    output logic [31:0]                        o_code_blue,
    output logic [31:0]                        o_code_white,
    output logic                               o_led_changed,
    output logic                               o_frame_dirty,
    output logic                               o_frame_done,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lfse_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int AW = lfse_pkg::LED_AW;
    localparam int NC = lfse_pkg::CHAN_NUM;

    // configuration
    logic [7:0]          r_step;
    logic                w_reg_sel;

    // position counter
    logic [AW-1:0]       r_led_pos;
    logic [AW-1:0]       n_led_pos;

    // lane stage
    logic                r_s1_valid;
    logic [7:0]          r_s1_tgt [NC];
    logic                r_s1_jump;
    logic                r_s1_end;
    logic [AW-1:0]       r_s1_pos;
    logic                r_fwd_hit;
    logic [31:0]         r_fwd_word;

    logic                w_accept;
    logic                w_out_free;
    logic                w_s1_adv;
    logic [31:0]         w_rd_data;
    logic [31:0]         w_old_word;
    logic [31:0]         w_new_word;
    logic [7:0]          w_k;
    logic [NC-1:0][31:0] w_code;
    lfse_pkg::t_mem_wr   w_mem_wr;
    lfse_pkg::t_s1_ctl   w_s1_ctl;

    // ---------------- configuration ----------------
    assign w_reg_sel = paddr[lfse_pkg::APB_AW-1] == lfse_pkg::REG_SMOOTH_STEP;
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? {24'd0, r_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= lfse_pkg::STEP_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_step <= pwdata[7:0];
        end
    end

    // ---------------- handshake ----------------
    assign w_s1_adv = r_s1_valid && w_out_free;
    assign o_stall  = r_s1_valid && !w_out_free;
    assign w_accept = i_valid && !o_stall;

    // ---------------- position ----------------
    always_comb begin
        if (i_frame_end || r_led_pos == AW'(lfse_pkg::LED_COUNT - 1)) begin
            n_led_pos = '0;
        end else begin
            n_led_pos = r_led_pos + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_pos  <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_led_pos  <= n_led_pos;
                r_s1_valid <= 1'b1;
                // bypass the store when the previous LED wrote this entry now
                r_fwd_hit  <= w_s1_adv && (r_s1_pos == r_led_pos);
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_tgt[lfse_pkg::CH_RED]   <= i_target_red;
            r_s1_tgt[lfse_pkg::CH_GREEN] <= i_target_green;
            r_s1_tgt[lfse_pkg::CH_BLUE]  <= i_target_blue;
            r_s1_tgt[lfse_pkg::CH_WHITE] <= i_target_white;
            r_s1_jump                    <= i_jump_now;
            r_s1_end                     <= i_frame_end;
            r_s1_pos                     <= r_led_pos;
            r_fwd_word                   <= w_new_word;
        end
    end

    // ---------------- colour store ----------------
    assign w_mem_wr.en   = w_s1_adv;
    assign w_mem_wr.addr = r_s1_pos;
    assign w_mem_wr.data = w_new_word;

    lfse_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_led_pos),
        .i_wr      (w_mem_wr),
        .o_rd_data (w_rd_data)
    );

    assign w_old_word = r_fwd_hit ? r_fwd_word : w_rd_data;
    assign w_k        = r_s1_jump ? lfse_pkg::STEP_FULL : r_step;

    // ---------------- channel lanes ----------------
    for (genvar c = 0; c < NC; c++) begin : g_lane
        lfse_lane u_lane (
            .i_cur  (w_old_word[8*c +: 8]),
            .i_tgt  (r_s1_tgt[c]),
            .i_k    (w_k),
            .o_nxt  (w_new_word[8*c +: 8]),
            .o_code (w_code[c])
        );
    end

    // ---------------- merge and output ----------------
    assign w_s1_ctl.load      = w_s1_adv;
    assign w_s1_ctl.frame_end = r_s1_end;

    lfse_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_s1_ctl),
        .i_old_word    (w_old_word),
        .i_new_word    (w_new_word),
        .i_code        (w_code),
        .i_stall       (i_stall),
        .o_free        (w_out_free),
        .o_valid       (o_valid),
        .o_code_green  (o_code_green),
        .o_code_red    (o_code_red),
        .o_code_blue   (o_code_blue),
        .o_code_white  (o_code_white),
        .o_led_changed (o_led_changed),
        .o_frame_dirty (o_frame_dirty),
        .o_frame_done  (o_frame_done)
    );

endmodule

`default_nettype wire

// ===== rtl/lfse_checker.sv =====
// ----------------------------------------------------------------------------
// lfse_checker: port-level checks for the LED frame smooth encoder
// Watches the result channel for hold behaviour, line-code format and the
// frame-dirty bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module lfse_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_code_green,
    input wire logic [31:0] o_code_red,
    input wire logic [31:0] o_code_blue,
    input wire logic [31:0] o_code_white,
    input wire logic        o_led_changed,
    input wire logic        o_frame_dirty,
    input wire logic        o_frame_done
);

    localparam logic [31:0] LOW_MASK = 32'h3333_3333;
    localparam logic [31:0] TOP_MASK = 32'h8888_8888;

    logic r_frame_start;
    logic r_prev_dirty;
    logic w_out_xfer;

    assign w_out_xfer = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_start <= 1'b1;
            r_prev_dirty  <= 1'b0;
        end else if (w_out_xfer) begin
            r_frame_start <= o_frame_done;
            r_prev_dirty  <= o_frame_dirty && !o_frame_done;
        end
    end

    // a stalled result stays valid and holds its green and red codes and frame flags
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_green) && $stable(o_code_red)
            && $stable(o_frame_dirty) && $stable(o_frame_done))
        else $error("result changed while stalled");

    // every nibble is 1000 or 1100
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_code_green & LOW_MASK) == 32'd0)
            && ((o_code_red & LOW_MASK) == 32'd0)
            && ((o_code_blue & LOW_MASK) == 32'd0)
            && ((o_code_white & LOW_MASK) == 32'd0)
            && ((o_code_green & TOP_MASK) == TOP_MASK)
            && ((o_code_red & TOP_MASK) == TOP_MASK)
            && ((o_code_blue & TOP_MASK) == TOP_MASK)
            && ((o_code_white & TOP_MASK) == TOP_MASK))
        else $error("malformed line code");

    // first LED of a frame: dirty is exactly its own change
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer && r_frame_start |-> o_frame_dirty == o_led_changed)
        else $error("frame dirty not cleared at frame start");

    // dirty accumulates within a frame
    a_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> o_frame_dirty == (r_prev_dirty || o_led_changed))
        else $error("frame dirty does not accumulate");

endmodule

bind led_frame_smooth_encode_unit lfse_checker u_lfse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_code_green  (o_code_green),
    .o_code_red    (o_code_red),
    .o_code_blue   (o_code_blue),
    .o_code_white  (o_code_white),
    .o_led_changed (o_led_changed),
    .o_frame_dirty (o_frame_dirty),
    .o_frame_done  (o_frame_done)
);

`default_nettype wire
